FILE: src/iphc_pkg.sv
// shared types, constants and helpers for the ipv4 header checker
// no dependencies; used by the result interface, the output buffer and the top level
package iphc_pkg;

  // error codes carried in the result
  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_SHORT    = 2'd1,
    ERR_HDR_LEN  = 2'd2,
    ERR_CHECKSUM = 2'd3
  } err_code_t;

  // byte positions within the header
  localparam logic [5:0] IDX_IHL       = 6'd0;
  localparam logic [5:0] IDX_TOS       = 6'd1;
  localparam logic [5:0] IDX_TLEN_HI   = 6'd2;
  localparam logic [5:0] IDX_TLEN_LO   = 6'd3;
  localparam logic [5:0] IDX_CSUM_HI   = 6'd10;
  localparam logic [5:0] IDX_CSUM_LO   = 6'd11;
  localparam logic [5:0] IDX_SRC_FIRST = 6'd12;
  localparam logic [5:0] IDX_SRC_LAST  = 6'd15;
  localparam logic [5:0] IDX_DST_FIRST = 6'd16;
  localparam logic [5:0] IDX_DST_LAST  = 6'd19;

  localparam logic [5:0] MIN_HDR_BYTES = 6'd20;
  localparam logic [5:0] COUNT_MAX     = 6'd63;
  localparam logic [7:0] DSCP_MASK     = 8'hfc;
  localparam logic [1:0] ECN_MASK      = 2'b11;

  // one result item
  typedef struct packed {
    logic        packet_ok;
    logic [1:0]  error_code;
    logic [3:0]  ihl_words;
    logic [15:0] computed_checksum;
    logic [15:0] stored_checksum;
    logic [15:0] total_length;
    logic [15:0] payload_length;
    logic [7:0]  dscp_bits;
    logic [1:0]  ecn_bits;
    logic [31:0] source_address;
    logic [31:0] dest_address;
  } result_t;

  // 16-bit ones' complement add with end-around carry
  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

FILE: src/iphc_in_if.sv
// input channel: one packet byte per transfer with an end-of-packet flag
// no dependencies
interface iphc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

FILE: src/iphc_out_if.sv
// result channel: one header check result per transfer
// depends on iphc_pkg for the result type
interface iphc_out_if;
  logic              valid;
  logic              ready;
  iphc_pkg::result_t res;

  modport source (output valid, output res, input ready);
  modport sink   (input valid, input res, output ready);
endinterface

FILE: src/ipv4_header_check.sv
// ipv4 header checksum verifier; depends on iphc_pkg, iphc_in_if, iphc_out_if, iphc_out_buf
// Takes an IPv4 packet one byte per transfer, network order, last byte flagged. It keeps a
// ones' complement sum over the IHL*4 header bytes (checksum field as zero), captures the
// header fields and pushes one result per packet into the buffer as the last byte is taken.
// One byte per cycle while ready: the per-byte update is a single 16-bit end-around add.
// Results sit in a two-entry buffer; in_chan.ready drops only while both entries are full.
module ipv4_header_check (
  input  logic       clk,
  input  logic       rst_n,
  iphc_in_if.sink    in_chan,
  iphc_out_if.source out_chan
);

  logic [5:0]  byte_count_r, byte_count_nxt, upd_count;
  logic [15:0] sum_acc_r, sum_acc_nxt, upd_sum;
  logic [7:0]  high_byte_r, high_byte_nxt, upd_high;
  logic [3:0]  header_words_r, header_words_nxt, upd_hw;
  logic [7:0]  tos_byte_r, tos_byte_nxt, upd_tos;
  logic [15:0] total_len_r, total_len_nxt, upd_tlen;
  logic [15:0] checksum_r, checksum_nxt, upd_csum;
  logic [31:0] source_r, source_nxt, upd_src;
  logic [31:0] dest_r, dest_nxt, upd_dst;

  logic                buf_full;
  logic                in_xfer;
  logic                res_push;
  logic [5:0]          idx;
  logic [5:0]          hdr_bytes;
  logic [15:0]         computed;
  iphc_pkg::err_code_t err;
  iphc_pkg::result_t   res;

  assign in_chan.ready = !buf_full;
  assign in_xfer       = in_chan.valid && in_chan.ready;
  assign res_push      = in_xfer && in_chan.last_byte;
  assign idx           = byte_count_r;

  // per-byte field capture and checksum accumulation
  always_comb begin
    upd_count = byte_count_r;
    upd_sum   = sum_acc_r;
    upd_high  = high_byte_r;
    upd_hw    = header_words_r;
    upd_tos   = tos_byte_r;
    upd_tlen  = total_len_r;
    upd_csum  = checksum_r;
    upd_src   = source_r;
    upd_dst   = dest_r;
    if (in_xfer && idx != iphc_pkg::COUNT_MAX) begin
      if (idx == iphc_pkg::IDX_IHL) begin
        upd_hw = in_chan.data_byte[3:0];
      end else if (idx == iphc_pkg::IDX_TOS) begin
        upd_tos = in_chan.data_byte;
      end else if (idx == iphc_pkg::IDX_TLEN_HI || idx == iphc_pkg::IDX_TLEN_LO) begin
        upd_tlen = {total_len_r[7:0], in_chan.data_byte};
      end else if (idx == iphc_pkg::IDX_CSUM_HI || idx == iphc_pkg::IDX_CSUM_LO) begin
        upd_csum = {checksum_r[7:0], in_chan.data_byte};
      end else if (idx >= iphc_pkg::IDX_SRC_FIRST && idx <= iphc_pkg::IDX_SRC_LAST) begin
        upd_src = {source_r[23:0], in_chan.data_byte};
      end else if (idx >= iphc_pkg::IDX_DST_FIRST && idx <= iphc_pkg::IDX_DST_LAST) begin
        upd_dst = {dest_r[23:0], in_chan.data_byte};
      end
      // header bytes only; the checksum word itself counts as zero
      if (idx < {upd_hw, 2'b00}) begin
        if (!idx[0]) begin
          upd_high = in_chan.data_byte;
        end else if (idx != iphc_pkg::IDX_CSUM_LO) begin
          upd_sum = iphc_pkg::ones_add(sum_acc_r, {high_byte_r, in_chan.data_byte});
        end
      end
      upd_count = idx + 6'd1;
    end
  end

  // end-of-packet checks and result fields
  always_comb begin
    hdr_bytes = {upd_hw, 2'b00};
    computed  = ~upd_sum;
    priority if (upd_count < iphc_pkg::MIN_HDR_BYTES) begin
      err = iphc_pkg::ERR_SHORT;
    end else if (hdr_bytes < iphc_pkg::MIN_HDR_BYTES || hdr_bytes > upd_count) begin
      err = iphc_pkg::ERR_HDR_LEN;
    end else if (computed != upd_csum) begin
      err = iphc_pkg::ERR_CHECKSUM;
    end else begin
      err = iphc_pkg::ERR_NONE;
    end
    res                   = '0;
    res.packet_ok         = (err == iphc_pkg::ERR_NONE);
    res.error_code        = err;
    res.ihl_words         = upd_hw;
    res.computed_checksum = computed;
    res.stored_checksum   = upd_csum;
    if (err == iphc_pkg::ERR_NONE) begin
      res.total_length   = upd_tlen;
      res.payload_length = (upd_tlen > {10'd0, hdr_bytes}) ? upd_tlen - {10'd0, hdr_bytes}
                                                           : 16'd0;
      res.dscp_bits      = upd_tos & iphc_pkg::DSCP_MASK;
      res.ecn_bits       = upd_tos[1:0] & iphc_pkg::ECN_MASK;
      res.source_address = upd_src;
      res.dest_address   = upd_dst;
    end
  end

  // packet state clears after the last byte
  always_comb begin
    if (res_push) begin
      byte_count_nxt   = '0;
      sum_acc_nxt      = '0;
      high_byte_nxt    = '0;
      header_words_nxt = '0;
      tos_byte_nxt     = '0;
      total_len_nxt    = '0;
      checksum_nxt     = '0;
      source_nxt       = '0;
      dest_nxt         = '0;
    end else begin
      byte_count_nxt   = upd_count;
      sum_acc_nxt      = upd_sum;
      high_byte_nxt    = upd_high;
      header_words_nxt = upd_hw;
      tos_byte_nxt     = upd_tos;
      total_len_nxt    = upd_tlen;
      checksum_nxt     = upd_csum;
      source_nxt       = upd_src;
      dest_nxt         = upd_dst;
    end
  end

  // packet state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r   <= '0;
      sum_acc_r      <= '0;
      high_byte_r    <= '0;
      header_words_r <= '0;
      tos_byte_r     <= '0;
      total_len_r    <= '0;
      checksum_r     <= '0;
      source_r       <= '0;
      dest_r         <= '0;
    end else begin
      byte_count_r   <= byte_count_nxt;
      sum_acc_r      <= sum_acc_nxt;
      high_byte_r    <= high_byte_nxt;
      header_words_r <= header_words_nxt;
      tos_byte_r     <= tos_byte_nxt;
      total_len_r    <= total_len_nxt;
      checksum_r     <= checksum_nxt;
      source_r       <= source_nxt;
      dest_r         <= dest_nxt;
    end
  end

  // result buffer
  iphc_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res),
    .full      (buf_full),
    .out_chan  (out_chan)
  );

`ifndef SYNTHESIS
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |=> byte_count_r == 6'd0 && sum_acc_r == 16'd0 && header_words_r == 4'd0)
    else $error("packet state not cleared after last byte");

  a_ok_matches_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |->
      out_chan.res.packet_ok == (out_chan.res.error_code == iphc_pkg::ERR_NONE))
    else $error("packet_ok disagrees with error code");

  a_invalid_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.res.packet_ok |->
      out_chan.res.source_address == 32'd0 && out_chan.res.dest_address == 32'd0 &&
      out_chan.res.total_length == 16'd0 && out_chan.res.payload_length == 16'd0)
    else $error("invalid packet result carries header fields");

  a_count_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    byte_count_r == iphc_pkg::COUNT_MAX && !res_push |=> byte_count_r == iphc_pkg::COUNT_MAX)
    else $error("byte count left saturation");
`endif

endmodule

FILE: src/iphc_out_buf.sv
// two-entry result buffer between the checker and the result channel
// depends on iphc_pkg and iphc_out_if
module iphc_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  iphc_pkg::result_t push_data,
  output logic              full,
  iphc_out_if.source        out_chan
);

  logic [1:0]        cnt_r, cnt_nxt;
  iphc_pkg::result_t head_r, head_nxt;
  iphc_pkg::result_t tail_r, tail_nxt;
  logic              pop;

  assign pop            = out_chan.valid && out_chan.ready;
  assign full           = (cnt_r == 2'd2);
  assign out_chan.valid = (cnt_r != 2'd0);
  assign out_chan.res   = head_r;

  // occupancy and entry movement
  always_comb begin
    cnt_nxt  = cnt_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    unique case ({push, pop})
      2'b10: begin
        if (cnt_r == 2'd0) head_nxt = push_data;
        else tail_nxt = push_data;
        cnt_nxt = cnt_r + 2'd1;
      end
      2'b01: begin
        head_nxt = tail_r;
        cnt_nxt  = cnt_r - 2'd1;
      end
      2'b11: begin
        if (cnt_r == 2'd1) begin
          head_nxt = push_data;
        end else begin
          head_nxt = tail_r;
          tail_nxt = push_data;
        end
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  // occupancy register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("result buffer count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> cnt_r != 2'd2) else $error("result pushed into full buffer");

  a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !push |=> cnt_r == $past(cnt_r) - 2'd1) else $error("pop did not drain buffer");
`endif

endmodule
